// ===== rtl/shp3x3_pkg.sv =====
// Shared constants and types for the 3x3 sharpen stream filter.
`default_nettype none

package shp3x3_pkg;

   // Field widths
   localparam int SAMPLE_W     = 8;
   localparam int CFG_WIDTH_W  = 12;
   localparam int CFG_HEIGHT_W = 16;
   localparam int CFG_CHAN_W   = 3;
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = 16;

   // Kernel accumulator: 5*255 down to -4*255 fits in 12 signed bits
   localparam int ACC_W = 12;

   // Default sizing of the line store
   localparam int DEFAULT_MAX_WIDTH    = 2048;
   localparam int DEFAULT_MAX_CHANNELS = 4;

   // Result queue depth
   localparam int OUT_DEPTH = 4;

   // Register reset values
   localparam logic [CFG_WIDTH_W-1:0]  RST_IMAGE_WIDTH   = 12'd640;
   localparam logic [CFG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT  = 16'd480;
   localparam logic [CFG_CHAN_W-1:0]   RST_CHANNEL_COUNT = 3'd3;

   // Register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_IMAGE_WIDTH   = 2'd0,
      CSR_IMAGE_HEIGHT  = 2'd1,
      CSR_CHANNEL_COUNT = 2'd2
   } csr_index_type;

   // One queued result
   typedef struct packed {
      logic                frame_end;
      logic                last_in_run;
      logic [SAMPLE_W-1:0] value;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/shp3x3_ram.sv =====
// Generic RAM: one write port, two registered read ports (read returns old data on collision).
`default_nettype none

module shp3x3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr_a,
   input  wire logic [AW-1:0]    rd_addr_b,
   output logic      [WIDTH-1:0] rd_data_a,
   output logic      [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   // Storage and read registers
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

// ===== rtl/sharpen_3x3_stream_filter.sv =====
// Top level: 3x3 cross-kernel sharpen over a raster stream of interleaved samples.
//
// Usage:
//   req_* carries one 8-bit channel sample per transaction in raster order;
//   req_tuser high marks the first sample of a frame and restarts the row and
//   sample counters. rsp_* carries results: one per input sample in rows 1 and
//   up (the output for the row above), plus a second, border zero, for each
//   sample of the last row. Results run one row behind the input.
//   csr_* writes image_width, image_height and channel_count; write only while
//   no transaction is in flight.
// Path: each result is registered and then written into the result queue, which drives rsp.
// Throughput: one sample per cycle while rsp keeps up; in the last row of a frame
//   each sample yields two results, and req_tready paces the input to the single result per cycle on rsp.
// Storage: one 16-bit RAM entry per sample position holds the two previous
//   rows; it is read at the center and right-neighbor positions and written
//   back in the cycle after the read. No clearing pass: the first row only fills it.
// Reset clears the counters, the pipeline and the result queue and loads the
//   register defaults (640 x 480, 3 channels). When rsp stalls, up to four
//   results queue and req_tready drops once two more could not fit.
`default_nettype none

module sharpen_3x3_stream_filter #(
   parameter int MAX_WIDTH    = shp3x3_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_CHANNELS = shp3x3_pkg::DEFAULT_MAX_CHANNELS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // req_tdata: [7:0] sample
   input  wire logic [shp3x3_pkg::SAMPLE_W-1:0]   req_tdata,
   // req_tuser: [0] frame_start
   input  wire logic                              req_tuser,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // rsp_tdata: [7:0] filtered_value
   output logic      [shp3x3_pkg::SAMPLE_W-1:0]   rsp_tdata,
   output logic                                   rsp_tlast,
   // rsp_tuser: [0] frame_end
   output logic                                   rsp_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic                              csr_we,
   input  wire logic [shp3x3_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [shp3x3_pkg::CSR_DATA_W-1:0] csr_wdata
);

   import shp3x3_pkg::*;

   localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS;
   localparam int POS_W  = $clog2(DEPTH);
   localparam int LEN_W  = $clog2(DEPTH + 1);
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int XW     = ((LEN_W > CFG_CHAN_W) ? LEN_W : CFG_CHAN_W) + 1;
   localparam int CMP_W  = ((CFG_WIDTH_W > WID_W) ? CFG_WIDTH_W : WID_W) + 1;
   localparam int PROD_W = WID_W + CFG_CHAN_W;
   localparam int PTR_W  = $clog2(OUT_DEPTH);
   localparam int CNT_W  = $clog2(OUT_DEPTH + 1);
   localparam int WORD_W = 2 * SAMPLE_W;

   // ------------------------------------------------------------------
   // Configuration registers
   logic [CFG_WIDTH_W-1:0]  cfg_width_ff;
   logic [CFG_HEIGHT_W-1:0] cfg_height_ff;
   logic [CFG_CHAN_W-1:0]   cfg_chans_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= RST_IMAGE_WIDTH;
         cfg_height_ff <= RST_IMAGE_HEIGHT;
         cfg_chans_ff  <= RST_CHANNEL_COUNT;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_IMAGE_WIDTH:   cfg_width_ff  <= csr_wdata[CFG_WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT:  cfg_height_ff <= csr_wdata[CFG_HEIGHT_W-1:0];
            CSR_CHANNEL_COUNT: cfg_chans_ff  <= csr_wdata[CFG_CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective geometry, clamped to the supported range
   logic [CMP_W-1:0]        width_ext;
   logic [WID_W-1:0]        width_eff;
   logic [CFG_CHAN_W-1:0]   chans_eff;
   logic [CFG_HEIGHT_W-1:0] height_eff;
   logic [PROD_W-1:0]       len_full;
   logic [LEN_W-1:0]        len;

   always_comb begin
      width_ext = CMP_W'(cfg_width_ff);
      if (width_ext < CMP_W'(3)) begin
         width_eff = WID_W'(3);
      end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
         width_eff = WID_W'(MAX_WIDTH);
      end else begin
         width_eff = WID_W'(width_ext);
      end
      if (cfg_chans_ff == '0) begin
         chans_eff = CFG_CHAN_W'(1);
      end else if (cfg_chans_ff > CFG_CHAN_W'(MAX_CHANNELS)) begin
         chans_eff = CFG_CHAN_W'(MAX_CHANNELS);
      end else begin
         chans_eff = cfg_chans_ff;
      end
      height_eff = (cfg_height_ff < CFG_HEIGHT_W'(3)) ? CFG_HEIGHT_W'(3) : cfg_height_ff;
      len_full   = PROD_W'(width_eff) * PROD_W'(chans_eff);
      len        = LEN_W'(len_full);
   end

   // ------------------------------------------------------------------
   // Stage 0: position tracking and RAM read issue
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic [CFG_HEIGHT_W-1:0] row_ff, row_in;
   logic [POS_W-1:0]        pos_start, p0, addr_b;
   logic [CFG_HEIGHT_W-1:0] row_start, r0;
   logic [XW-1:0]           p_next_x;
   logic                    wrap, last_row, has_main, interior, fend, accept;

   assign accept = req_tvalid & req_tready;

   always_comb begin
      pos_start = req_tuser ? '0 : pos_ff;
      row_start = req_tuser ? '0 : row_ff;
      p0        = (XW'(pos_start) >= XW'(len)) ? '0 : pos_start;
      r0        = (row_start >= height_eff) ? '0 : row_start;
      last_row  = (r0 == height_eff - CFG_HEIGHT_W'(1));
      has_main  = (r0 != '0);
      interior  = (r0 >= CFG_HEIGHT_W'(2)) && (XW'(p0) >= XW'(chans_eff)) &&
                  (XW'(p0) + XW'(chans_eff) < XW'(len));
      p_next_x  = XW'(p0) + XW'(1);
      wrap      = (p_next_x == XW'(len));
      fend      = last_row && wrap;
      addr_b    = interior ? POS_W'(XW'(p0) + XW'(chans_eff)) : p0;
      pos_in    = wrap ? '0 : POS_W'(p_next_x);
      if (!wrap) begin
         row_in = r0;
      end else if (last_row) begin
         row_in = '0;
      end else begin
         row_in = r0 + CFG_HEIGHT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1 registers
   logic                s1_valid_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic [POS_W-1:0]    s1_addr_ff;
   logic                s1_main_ff, s1_interior_ff, s1_last_row_ff, s1_fend_ff;
   logic                s1_fwd_a_ff, s1_fwd_b_ff;
   logic [WORD_W-1:0]   s1_fwd_word_ff;

   // RAM word: [7:0] row above the current input row, [15:8] the row above that
   logic [WORD_W-1:0] rd_data_a, rd_data_b, a_word, wr_data;
   logic [SAMPLE_W-1:0] b_newer;

   shp3x3_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_line_ram (
      .clock     (clock),
      .wr_en     (s1_valid_ff),
      .wr_addr   (s1_addr_ff),
      .wr_data   (wr_data),
      .rd_en     (accept),
      .rd_addr_a (p0),
      .rd_addr_b (addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Forward the write-back that lands in the same cycle as the read
   always_comb begin
      a_word  = s1_fwd_a_ff ? s1_fwd_word_ff : rd_data_a;
      b_newer = s1_fwd_b_ff ? s1_fwd_word_ff[SAMPLE_W-1:0] : rd_data_b[SAMPLE_W-1:0];
      wr_data = {a_word[SAMPLE_W-1:0], s1_sample_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff   <= req_tdata;
         s1_addr_ff     <= p0;
         s1_main_ff     <= has_main;
         s1_interior_ff <= interior;
         s1_last_row_ff <= last_row;
         s1_fend_ff     <= fend;
         s1_fwd_a_ff    <= s1_valid_ff && (p0 == s1_addr_ff);
         s1_fwd_b_ff    <= s1_valid_ff && (addr_b == s1_addr_ff);
         s1_fwd_word_ff <= wr_data;
      end
   end

   // Left neighbors: the last MAX_CHANNELS centers, newest first
   logic [SAMPLE_W-1:0] line_ff [MAX_CHANNELS];
   logic [SAMPLE_W-1:0] left;

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         line_ff[0] <= a_word[SAMPLE_W-1:0];
         for (int i = 1; i < MAX_CHANNELS; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   always_comb begin
      left = '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
         if (CFG_CHAN_W'(i + 1) == chans_eff) begin
            left = line_ff[i];
         end
      end
   end

   // Kernel: 5*center - up - down - left - right, saturated to 0..255
   logic signed [ACC_W-1:0] acc;
   logic [SAMPLE_W-1:0]     sat;
   result_type              res_main, res_border, push_first;
   logic [1:0]              n_push;

   always_comb begin
      acc = ($signed(ACC_W'(a_word[SAMPLE_W-1:0])) <<< 2)
          + $signed(ACC_W'(a_word[SAMPLE_W-1:0]))
          - $signed(ACC_W'(a_word[WORD_W-1:SAMPLE_W]))
          - $signed(ACC_W'(left))
          - $signed(ACC_W'(b_newer))
          - $signed(ACC_W'(s1_sample_ff));
      if (acc < 0) begin
         sat = '0;
      end else if (acc > $signed(ACC_W'(255))) begin
         sat = '1;
      end else begin
         sat = acc[SAMPLE_W-1:0];
      end
      res_main.value        = s1_interior_ff ? sat : '0;
      res_main.last_in_run  = !s1_last_row_ff;
      res_main.frame_end    = 1'b0;
      res_border.value      = '0;
      res_border.last_in_run = 1'b1;
      res_border.frame_end  = s1_fend_ff;
      push_first = s1_main_ff ? res_main : res_border;
      n_push     = s1_valid_ff ? (2'(s1_main_ff) + 2'(s1_last_row_ff)) : 2'd0;
   end

   // ------------------------------------------------------------------
   // Result queue
   result_type       fifo_ff [OUT_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] fifo_count_ff;
   logic             pop;

   assign pop        = rsp_tvalid & rsp_tready;
   assign rsp_tvalid = (fifo_count_ff != '0);
   assign rsp_tdata  = fifo_ff[rd_ptr_ff].value;
   assign rsp_tlast  = fifo_ff[rd_ptr_ff].last_in_run;
   assign rsp_tuser  = fifo_ff[rd_ptr_ff].frame_end;

   // Room for the item in stage 1 plus two more results
   assign req_tready = ((CNT_W + 1)'(fifo_count_ff) + (CNT_W + 1)'(n_push))
                       <= (CNT_W + 1)'(OUT_DEPTH - 2);

   always_ff @(posedge clock) begin
      if (n_push != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= push_first;
      end
      if (n_push == 2'd2) begin
         fifo_ff[wr_ptr_ff + PTR_W'(1)] <= res_border;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
      end else begin
         wr_ptr_ff     <= wr_ptr_ff + PTR_W'(n_push);
         rd_ptr_ff     <= rd_ptr_ff + PTR_W'(pop);
         fifo_count_ff <= fifo_count_ff + CNT_W'(n_push) - CNT_W'(pop);
      end
   end

   // ------------------------------------------------------------------
   // Assertions
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_count_ff <= CNT_W'(OUT_DEPTH))
      else $error("result queue overflow");

   a_fend_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame end without end of run");

   a_fwd_b_border: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_fwd_b_ff |-> !s1_interior_ff)
      else $error("right-neighbor forward on an interior sample");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

`default_nettype wire
